// ===== src/frame_ring_allocator_unit_macros.svh =====
// Assertion helpers for the checker file of the ring allocator.
`ifndef FRAME_RING_ALLOCATOR_UNIT_MACROS_SVH
`define FRAME_RING_ALLOCATOR_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FRA_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FRA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/fra_pkg.sv =====
package fra_pkg;

   localparam int FRAME_SLOTS_DEF    = 4;
   localparam int MAX_ALLOCS_DEF     = 1024;

   localparam logic [31:0] CAP_RESET = 32'd134217728;
   localparam logic [31:0] CAP_LIMIT = 32'h8000_0000;

   localparam logic CMD_ALLOC   = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NO_SPACE = 2'd1;
   localparam logic [1:0] STATUS_IDX_FULL = 2'd2;

   // Dividend of the remainder unit: a 31-bit pointer plus up to 32 bits of offset.
   localparam int DIVIDEND_W = 34;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [31:0]           divisor;
   } fra_mod_req_type;

endpackage

// ===== src/fra_mod.sv =====
module fra_mod (
   input  logic                      clock,
   input  logic                      reset,
   input  fra_pkg::fra_mod_req_type  mod_req,
   output logic                      done,
   output logic [31:0]               remainder
);
   import fra_pkg::*;

   localparam int CNT_W = $clog2(DIVIDEND_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIVIDEND_W - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [DIVIDEND_W-1:0] dividend_ff, dividend_in;
   logic [31:0]           divisor_ff, divisor_in;
   logic [31:0]           rem_ff, rem_in;
   logic [32:0]           trial;
   logic [32:0]           diff;

   // Restoring remainder: one dividend bit shifted in per cycle, MSB first.
   assign trial = {rem_ff, dividend_ff[DIVIDEND_W-1]};
   assign diff  = trial - {1'b0, divisor_ff};

   always_comb begin
      busy_in     = busy_ff;
      done_in     = 1'b0;
      count_in    = count_ff;
      dividend_in = dividend_ff;
      divisor_in  = divisor_ff;
      rem_in      = rem_ff;
      if (mod_req.start) begin
         busy_in     = 1'b1;
         count_in    = '0;
         dividend_in = mod_req.dividend;
         divisor_in  = mod_req.divisor;
         rem_in      = '0;
      end else if (busy_ff) begin
         rem_in      = (trial >= {1'b0, divisor_ff}) ? diff[31:0] : trial[31:0];
         dividend_in = {dividend_ff[DIVIDEND_W-2:0], 1'b0};
         count_in    = count_ff + CNT_W'(1);
         if (count_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff    <= count_in;
      dividend_ff <= dividend_in;
      divisor_ff  <= divisor_in;
      rem_ff      <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== src/frame_ring_allocator_unit.sv =====
// Per-frame ring allocator. A ring of ring_capacity bytes (values above 2^31 act as
// 2^31) is handed out front to back, each allocation charged to a frame-in-flight
// slot. An allocate request pads the end pointer to a 2^align_log2 boundary and,
// if the padded size fits, answers with the offset and the allocation's index in
// its slot; otherwise the status reports "out of space" (checked first) or "slot
// index full". A release request moves the start pointer past the slot's bytes and
// clears the slot's counters. One request is worked on at a time and every request
// gives exactly one response. A request that fails, or that releases a slot while
// the capacity is zero or names an unknown slot, goes from the slot read straight
// to its response. A successful allocate or an ordinary release also runs the
// bit-serial remainder unit that wraps pointers modulo the capacity: the slot is
// read and the unit started, then 34 steps follow (one bit of a 34-bit dividend per
// cycle), then the remainder is collected and, for an allocate, the end pointer is
// wrapped. The next request can be accepted in the same cycle as the response is
// offered. The per-slot counters live in a small synchronous memory with a
// registered read; per-entry valid bits cleared by reset make unwritten entries
// read as zero, so no clearing pass follows reset. A new request may be accepted
// while the previous response still waits to be taken.
module frame_ring_allocator_unit #(
   parameter int FRAME_SLOTS          = fra_pkg::FRAME_SLOTS_DEF,
   parameter int MAX_ALLOCS_PER_FRAME = fra_pkg::MAX_ALLOCS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [31:0] req_request_bytes,
   input  logic [4:0]  req_align_log2,
   input  logic [1:0]  req_frame_slot,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [30:0] rsp_alloc_offset,
   output logic [9:0]  rsp_alloc_index,
   output logic [31:0] rsp_used_bytes_now,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);
   import fra_pkg::*;

   localparam int SLOT_W = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
   localparam int CNT_W  = $clog2(MAX_ALLOCS_PER_FRAME + 1);
   localparam int ENT_W  = 32 + CNT_W;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ALLOCS_PER_FRAME);

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOOK,
      S_DIV,
      S_WRAP,
      S_DONE
   } state_type;

   state_type          state_ff, state_in;

   // Ring state.
   logic [31:0]        cap_ff, cap_in;
   logic [30:0]        end_ff, end_in;
   logic [30:0]        start_ff, start_in;
   logic [31:0]        used_ff, used_in;

   // The request under way.
   logic               cmd_ff, cmd_in;
   logic [31:0]        req_bytes_ff, req_bytes_in;
   logic [30:0]        pad_ff, pad_in;
   logic [32:0]        asize_ff, asize_in;
   logic               slot_ok_ff, slot_ok_in;
   logic [SLOT_W-1:0]  slot_addr_ff, slot_addr_in;
   logic [32:0]        sum_ff, sum_in;

   // Pending response fields.
   logic [1:0]         status_ff, status_in;
   logic [30:0]        offset_ff, offset_in;
   logic [9:0]         index_ff, index_in;

   // Response register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [30:0]        rsp_offset_ff, rsp_offset_in;
   logic [9:0]         rsp_index_ff, rsp_index_in;
   logic [31:0]        rsp_used_ff, rsp_used_in;

   // Per-slot counter memory: byte count above, allocation count below.
   logic [ENT_W-1:0]       mem [FRAME_SLOTS];
   logic [FRAME_SLOTS-1:0] ent_valid_ff;
   logic [ENT_W-1:0]       rd_data_ff;
   logic                   rd_valid_ff;
   logic [SLOT_W-1:0]      rd_addr;
   logic                   mem_wr_en;
   logic [ENT_W-1:0]       mem_wr_data;

   logic [31:0]        cap_eff;
   logic               cap_zero;
   logic [31:0]        amask;
   logic [31:0]        slot_ext;
   logic               slot_ok_now;
   logic [31:0]        frame_bytes;
   logic [CNT_W-1:0]   frame_cnt;
   logic [31:0]        cnt_ext;
   logic [31:0]        fb_new;
   logic [33:0]        used_plus;
   logic [32:0]        wrap_diff;
   fra_mod_req_type    mod_req;
   logic               mod_done;
   logic [31:0]        mod_rem;

   // Capacities above 2^31 behave as exactly 2^31.
   assign cap_eff  = (cap_ff > CAP_LIMIT) ? CAP_LIMIT : cap_ff;
   assign cap_zero = (cap_ff == '0);

   assign amask       = (32'd1 << req_align_log2) - 32'd1;
   assign slot_ext    = 32'(req_frame_slot);
   assign slot_ok_now = (slot_ext < 32'(FRAME_SLOTS));
   assign rd_addr     = slot_ok_now ? slot_ext[SLOT_W-1:0] : '0;

   // An entry that has never been written reads as zero.
   assign frame_bytes = rd_valid_ff ? rd_data_ff[ENT_W-1:CNT_W] : '0;
   assign frame_cnt   = rd_valid_ff ? rd_data_ff[CNT_W-1:0] : '0;
   assign cnt_ext     = 32'(frame_cnt);
   assign fb_new      = frame_bytes + asize_ff[31:0];
   assign used_plus   = 34'(used_ff) + 34'(asize_ff);
   assign wrap_diff   = sum_ff - 33'(cap_eff);

   fra_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .mod_req   (mod_req),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   always_comb begin
      state_in      = state_ff;
      cap_in        = csr_wr_en ? csr_wr_data : cap_ff;
      end_in        = end_ff;
      start_in      = start_ff;
      used_in       = used_ff;
      cmd_in        = cmd_ff;
      req_bytes_in  = req_bytes_ff;
      pad_in        = pad_ff;
      asize_in      = asize_ff;
      slot_ok_in    = slot_ok_ff;
      slot_addr_in  = slot_addr_ff;
      sum_in        = sum_ff;
      status_in     = status_ff;
      offset_in     = offset_ff;
      index_in      = index_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_used_in   = rsp_used_ff;
      mem_wr_en     = 1'b0;
      mem_wr_data   = '0;
      mod_req       = '0;
      mod_req.divisor = cap_eff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               // The pad brings the end pointer up to the requested boundary.
               cmd_in       = req_cmd;
               req_bytes_in = req_request_bytes;
               pad_in       = (31'd0 - end_ff) & amask[30:0];
               asize_in     = 33'((31'd0 - end_ff) & amask[30:0]) + 33'(req_request_bytes);
               slot_ok_in   = slot_ok_now;
               slot_addr_in = rd_addr;
               status_in    = STATUS_OK;
               offset_in    = '0;
               index_in     = '0;
               state_in     = S_LOOK;
            end
         end
         S_LOOK: begin
            // The slot's counters arrive from memory in this cycle.
            if (cmd_ff == CMD_RELEASE) begin
               if (slot_ok_ff) begin
                  used_in   = (used_ff >= frame_bytes) ? used_ff - frame_bytes : '0;
                  mem_wr_en = 1'b1;
                  if (cap_zero) begin
                     start_in = '0;
                     state_in = S_DONE;
                  end else begin
                     mod_req.start    = 1'b1;
                     mod_req.dividend = DIVIDEND_W'(start_ff) + DIVIDEND_W'(frame_bytes);
                     state_in         = S_DIV;
                  end
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               priority if (cap_zero || (used_plus > 34'(cap_eff))) begin
                  status_in = STATUS_NO_SPACE;
                  state_in  = S_DONE;
               end else if (!slot_ok_ff || (frame_cnt >= MAX_CNT)) begin
                  status_in = STATUS_IDX_FULL;
                  state_in  = S_DONE;
               end else begin
                  index_in         = cnt_ext[9:0];
                  used_in          = used_plus[31:0];
                  mem_wr_en        = 1'b1;
                  mem_wr_data      = {fb_new, frame_cnt + CNT_W'(1)};
                  mod_req.start    = 1'b1;
                  mod_req.dividend = DIVIDEND_W'(end_ff) + DIVIDEND_W'(pad_ff);
                  state_in         = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (mod_done) begin
               if (cmd_ff == CMD_ALLOC) begin
                  offset_in = mod_rem[30:0];
                  sum_in    = 33'(mod_rem) + 33'(req_bytes_ff);
                  state_in  = S_WRAP;
               end else begin
                  start_in = mod_rem[30:0];
                  state_in = S_DONE;
               end
            end
         end
         S_WRAP: begin
            // The fit check bounds the request by the capacity, so one subtract wraps it.
            end_in   = (sum_ff >= 33'(cap_eff)) ? wrap_diff[30:0] : sum_ff[30:0];
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_offset_in = offset_ff;
               rsp_index_in  = index_ff;
               rsp_used_in   = used_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cap_ff       <= CAP_RESET;
         end_ff       <= '0;
         start_ff     <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         ent_valid_ff <= '0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         end_ff       <= end_in;
         start_ff     <= start_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         if (mem_wr_en) begin
            ent_valid_ff[slot_addr_ff] <= 1'b1;
         end
      end
      cmd_ff        <= cmd_in;
      req_bytes_ff  <= req_bytes_in;
      pad_ff        <= pad_in;
      asize_ff      <= asize_in;
      slot_ok_ff    <= slot_ok_in;
      slot_addr_ff  <= slot_addr_in;
      sum_ff        <= sum_in;
      status_ff     <= status_in;
      offset_ff     <= offset_in;
      index_ff      <= index_in;
      rsp_status_ff <= rsp_status_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_used_ff   <= rsp_used_in;
   end

   // Counter memory: one write and one registered read per cycle. The write of a
   // request always lands before the next request is accepted, so no bypass is needed.
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         mem[slot_addr_ff] <= mem_wr_data;
      end
      rd_data_ff  <= mem[rd_addr];
      rd_valid_ff <= ent_valid_ff[rd_addr];
   end

   assign req_ready          = (state_ff == S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_alloc_offset   = rsp_offset_ff;
   assign rsp_alloc_index    = rsp_index_ff;
   assign rsp_used_bytes_now = rsp_used_ff;

endmodule

// ===== src/fra_checker.sv =====
`include "frame_ring_allocator_unit_macros.svh"

module fra_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [30:0] rsp_alloc_offset,
   input logic [9:0]  rsp_alloc_index,
   input logic [31:0] rsp_used_bytes_now
);
   import fra_pkg::*;

   // A response that is not taken stays offered.
   `FRA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")

   // Failed allocations report no offset and no index.
   `FRA_ASSERT_SAME(a_fail_zero, rsp_valid && (rsp_status != STATUS_OK), (rsp_alloc_offset == '0) && (rsp_alloc_index == '0), "failed request carries an offset or index")

   // The used total never exceeds the largest capacity.
   `FRA_ASSERT_SAME(a_used_bound, rsp_valid, rsp_used_bytes_now <= CAP_LIMIT, "used total beyond the ring limit")

endmodule

bind frame_ring_allocator_unit fra_checker u_fra_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_status         (rsp_status),
   .rsp_alloc_offset   (rsp_alloc_offset),
   .rsp_alloc_index    (rsp_alloc_index),
   .rsp_used_bytes_now (rsp_used_bytes_now)
);
